/* hdl/aot_pkg.sv */
package aot_pkg;

    localparam int MAX_BOXES      = 64;
    localparam int COORD_BITS     = 24;
    localparam int IN_BITS        = 24;
    localparam int SIZE_BITS      = 23;
    localparam int OUT_COUNT_BITS = 7;

    // wide enough for a coordinate plus a size plus a shift without overflow
    localparam int WIDE_BITS  = ((COORD_BITS > IN_BITS) ? COORD_BITS : IN_BITS) + 3;
    localparam int COUNT_BITS = $clog2(MAX_BOXES + 1);
    localparam int INDEX_BITS = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    typedef logic signed [WIDE_BITS-1:0]  t_wide;
    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [IN_BITS-1:0]    t_in;
    typedef logic        [SIZE_BITS-1:0]  t_size;
    typedef logic        [COUNT_BITS-1:0] t_count;
    typedef logic        [INDEX_BITS-1:0] t_index;

    localparam t_wide COORD_MAX = t_wide'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam t_wide COORD_MIN = -COORD_MAX - t_wide'(1);

    // request actions
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_MOVE  = 2'd2;

    // operations carried down the cell chain
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_MOVE  = 2'd3;

    // add:   px/py = new min corner, w/h = size, idx = target entry
    // query: px = ex + sx, qx = ex + ew + sx (same for y), idx = entries held
    // move:  px/py = offset
    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        t_count     idx;
        t_wide      px;
        t_wide      qx;
        t_wide      py;
        t_wide      qy;
        t_size      w;
        t_size      h;
        logic       hit;
        logic       err;
        t_count     count;
    } t_token;

    function automatic t_coord sat_coord(input t_wide v);
        t_coord r;
        if (v > COORD_MAX) begin
            r = t_coord'(COORD_MAX);
        end else if (v < COORD_MIN) begin
            r = t_coord'(COORD_MIN);
        end else begin
            r = t_coord'(v);
        end
        return r;
    endfunction

endpackage

/* hdl/aot_front.sv */
module aot_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [1:0]     i_action,
    input  aot_pkg::t_in   i_coord_x,
    input  aot_pkg::t_in   i_coord_y,
    input  aot_pkg::t_size i_size_w,
    input  aot_pkg::t_size i_size_h,
    input  aot_pkg::t_in   i_shift_x,
    input  aot_pkg::t_in   i_shift_y,
    output aot_pkg::t_token o_tok,
    output aot_pkg::t_count o_count
);
    import aot_pkg::*;

    t_token r_tok;
    t_token n_tok;
    t_count r_count;
    t_count n_count;
    t_wide  cx;
    t_wide  cy;
    t_wide  sx;
    t_wide  sy;

    always_comb begin
        cx = t_wide'(sat_coord(t_wide'(i_coord_x)));
        cy = t_wide'(sat_coord(t_wide'(i_coord_y)));
        sx = t_wide'(i_shift_x);
        sy = t_wide'(i_shift_y);

        n_count   = r_count;
        n_tok     = '0;
        n_tok.valid = i_accept;
        n_tok.idx = r_count;
        n_tok.w   = i_size_w;
        n_tok.h   = i_size_h;
        n_tok.op  = OP_NONE;

        unique case (i_action)
            ACT_ADD: begin
                if (r_count >= t_count'(MAX_BOXES)) begin
                    n_tok.err = 1'b1;
                end else begin
                    n_tok.op = OP_ADD;
                    n_tok.px = t_wide'(sat_coord(cx - t_wide'(i_size_w >> 1)));
                    n_tok.py = t_wide'(sat_coord(cy - t_wide'(i_size_h >> 1)));
                    if (i_accept) begin
                        n_count = r_count + t_count'(1);
                    end
                end
            end
            ACT_QUERY: begin
                n_tok.op = OP_QUERY;
                n_tok.px = cx + sx;
                n_tok.qx = cx + t_wide'(i_size_w) + sx;
                n_tok.py = cy + sy;
                n_tok.qy = cy + t_wide'(i_size_h) + sy;
            end
            ACT_MOVE: begin
                n_tok.op = OP_MOVE;
                n_tok.px = sx;
                n_tok.py = sy;
            end
            default: begin
                n_tok.op = OP_NONE;
            end
        endcase

        n_tok.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_tok   <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_count = r_count;

endmodule

/* hdl/aot_cell.sv */
module aot_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  aot_pkg::t_index i_index,
    input  aot_pkg::t_token i_tok,
    output aot_pkg::t_token o_tok
);
    import aot_pkg::*;

    t_coord r_mx;
    t_coord r_my;
    t_size  r_w;
    t_size  r_h;
    t_token r_tok;
    t_token n_tok;
    t_wide  mx;
    t_wide  my;
    logic   occupied;
    logic   mine;
    logic   overlap;

    always_comb begin
        mx       = t_wide'(r_mx);
        my       = t_wide'(r_my);
        occupied = t_count'(i_index) < i_tok.idx;
        mine     = t_count'(i_index) == i_tok.idx;
        // shift already folded into the query bounds
        overlap  = (mx + t_wide'(r_w) >= i_tok.px) && (i_tok.qx >= mx) &&
                   (my + t_wide'(r_h) >= i_tok.py) && (i_tok.qy >= my);
        n_tok    = i_tok;
        if (i_tok.valid && i_tok.op == OP_QUERY && occupied && overlap) begin
            n_tok.hit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            case (i_tok.op)
                OP_ADD: begin
                    if (mine) begin
                        r_mx <= i_tok.px[COORD_BITS-1:0];
                        r_my <= i_tok.py[COORD_BITS-1:0];
                        r_w  <= i_tok.w;
                        r_h  <= i_tok.h;
                    end
                end
                OP_MOVE: begin
                    r_mx <= sat_coord(mx + i_tok.px);
                    r_my <= sat_coord(my + i_tok.py);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

/* hdl/aabb_overlap_table_unit.sv */
// Box table with overlap query. Each stored box lives in one cell of a chain
// of MAX_BOXES cells; a request enters a front register and then moves one
// cell per clock, adding, translating or testing against the box held there.
// A new request is taken every clock (busy stays low) and its result comes
// out on o_valid once it has passed the front register and all cell
// registers, in request order. The result is shown for one cycle only and
// cannot be held off.
module aabb_overlap_table_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_action,
    input  aot_pkg::t_in          i_coord_x,
    input  aot_pkg::t_in          i_coord_y,
    input  aot_pkg::t_size        i_size_w,
    input  aot_pkg::t_size        i_size_h,
    input  aot_pkg::t_in          i_shift_x,
    input  aot_pkg::t_in          i_shift_y,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic                  o_error,
    output logic [aot_pkg::OUT_COUNT_BITS-1:0] o_stored_count
);
    import aot_pkg::*;

    t_token w_tok [MAX_BOXES+1];
    t_count w_count;
    logic   accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    aot_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_action  (i_action),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .i_size_w  (i_size_w),
        .i_size_h  (i_size_h),
        .i_shift_x (i_shift_x),
        .i_shift_y (i_shift_y),
        .o_tok     (w_tok[0]),
        .o_count   (w_count)
    );

    for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
        aot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (t_index'(g)),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign o_valid        = w_tok[MAX_BOXES].valid;
    assign o_hit          = w_tok[MAX_BOXES].hit;
    assign o_error        = w_tok[MAX_BOXES].err;
    assign o_stored_count = OUT_COUNT_BITS'(w_tok[MAX_BOXES].count);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, MAX_BOXES + 1))
        else $error("result without matching request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= t_count'(MAX_BOXES))
        else $error("box count above table size");

    a_error_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |->
            (o_stored_count == OUT_COUNT_BITS'(MAX_BOXES) && !o_hit))
        else $error("error reported with table not full");

endmodule
